// ===== hw/rtl/clt_pkg.sv =====
package clt_pkg;

  localparam int unsigned KEYWORD_MAX_LEN = 4;

  // Held-byte count runs 0..KEYWORD_MAX_LEN; the index into the held bytes needs fewer bits.
  localparam int unsigned HC_W = $clog2(KEYWORD_MAX_LEN + 1);
  localparam int unsigned HI_W = $clog2(KEYWORD_MAX_LEN);
  // One byte can cause the held bytes, one token and one trailing result.
  localparam int unsigned ST_W = $clog2(KEYWORD_MAX_LEN + 3);

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QA_W = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] K_ERROR   = 4'd0;
  localparam logic [3:0] K_NEWLINE = 4'd1;
  localparam logic [3:0] K_NUMBER  = 4'd2;
  localparam logic [3:0] K_STRING  = 4'd3;
  localparam logic [3:0] K_EXEC    = 4'd4;
  localparam logic [3:0] K_PASS    = 4'd5;
  localparam logic [3:0] K_DEL     = 4'd6;
  localparam logic [3:0] K_PING    = 4'd7;
  localparam logic [3:0] K_STOP    = 4'd8;
  localparam logic [3:0] K_USER    = 4'd9;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam int unsigned KW_NUM   = 6;
  localparam int unsigned KW_SLOTS = 8;

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_SLOTS] = '{
    '{"E", "X", "E", "C", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "A", "S", "S", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "I", "N", "G", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"U", "S", "E", "R", 8'h00, 8'h00, 8'h00, 8'h00}
  };
  localparam int unsigned KW_LEN [KW_NUM] = '{4, 4, 3, 4, 4, 4};
  localparam logic [3:0] KW_KIND [KW_NUM] = '{K_EXEC, K_PASS, K_DEL, K_PING, K_STOP, K_USER};

  // Work for one input byte: held bytes first, then an optional token,
  // then an optional trailing result (the byte itself or a token).
  typedef struct packed {
    logic [KEYWORD_MAX_LEN-1:0][7:0] held;
    logic [HC_W-1:0]                 held_n;
    logic                            a_en;
    logic [3:0]                      a_kind;
    logic                            t_en;
    logic                            t_val;
    logic [3:0]                      t_kind;
    logic [7:0]                      data;
  } cmd_t;

endpackage

// ===== hw/rtl/command_line_tokenizer.sv =====
// Command line tokenizer.
// Input channel: one raw byte per beat (in_valid_i / in_stall_o / in_byte_i).
// Output channel: one result per beat. A result either carries one value
// byte of the current token (is_value_byte_o high) or closes a token with
// its kind in token_kind_o. last_of_run_o marks the final result caused by
// one input byte; a byte may cause zero to six results.
// The front classifies each byte in the cycle it is accepted and, if the
// byte causes any results, writes one entry describing all of them into a
// four-entry queue. The back reads the queue head and issues its results
// one per cycle while out_stall_i is low; each entry is registered in the
// queue first. Throughput: one byte per cycle while the queue has room,
// so a byte causing more than one result holds the back while they issue
// and long bursts fill the queue.
// Reset clears the tokenizer state and empties the queue; no clearing pass.
// When the receiver stalls, the current result holds, the queue fills and
// then in_stall_o rises until an entry is freed.
module command_line_tokenizer import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_value_byte_o,
  output logic [7:0] value_byte_o,
  output logic [3:0] token_kind_o,
  output logic       last_of_run_o
);

  logic full, push, pop, head_valid;
  cmd_t push_cmd, head_cmd;

  clt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_byte_i  (in_byte_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  clt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  clt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (head_valid),
    .cmd_i           (head_cmd),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .is_value_byte_o (is_value_byte_o),
    .value_byte_o    (value_byte_o),
    .token_kind_o    (token_kind_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== hw/rtl/clt_front.sv =====
module clt_front import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_NUM   = 3'd1;
  localparam logic [2:0] M_QUOTE = 3'd2;
  localparam logic [2:0] M_ESC   = 3'd3;
  localparam logic [2:0] M_WORD  = 3'd4;

  logic [2:0]                      mode_q, mode_d;
  logic [KEYWORD_MAX_LEN-1:0][7:0] held_q, held_d;
  logic [HC_W-1:0]                 cnt_q, cnt_d;
  logic                            long_q, long_d;

  logic       accept;
  logic       is_ctrl, is_digit, is_word;
  logic       kw_hit;
  logic [3:0] kw_kind;
  logic       run_idle;
  cmd_t       cmd;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign is_ctrl  = (in_byte_i < CH_SPACE) || (in_byte_i == CH_DEL);
  assign is_digit = (in_byte_i >= "0") && (in_byte_i <= "9");
  assign is_word  = (in_byte_i != CH_SPACE) && !is_ctrl;

  always_comb begin
    logic same;
    kw_hit  = 1'b0;
    kw_kind = K_STRING;
    for (int k = 0; k < KW_NUM; k++) begin
      same = (KW_LEN[k] <= KEYWORD_MAX_LEN) && (cnt_q == HC_W'(KW_LEN[k]));
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
        if (i < KW_LEN[k] && held_q[i] != KW_TEXT[k][i]) begin
          same = 1'b0;
        end
      end
      if (same && !kw_hit) begin
        kw_hit  = 1'b1;
        kw_kind = KW_KIND[k];
      end
    end
  end

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    cnt_d    = cnt_q;
    long_d   = long_q;
    run_idle = 1'b0;
    cmd        = '0;
    cmd.held   = held_q;
    cmd.data   = in_byte_i;
    cmd.a_kind = K_ERROR;
    cmd.t_kind = K_ERROR;

    unique case (mode_q)
      M_NUM: begin
        if (is_digit) begin
          cmd.t_en  = 1'b1;
          cmd.t_val = 1'b1;
        end else begin
          cmd.a_en   = 1'b1;
          cmd.a_kind = K_NUMBER;
          run_idle   = 1'b1;
        end
      end
      M_QUOTE: begin
        priority if (in_byte_i == CH_QUOTE) begin
          cmd.t_en   = 1'b1;
          cmd.t_kind = K_STRING;
          mode_d     = M_IDLE;
        end else if (in_byte_i == CH_BSLASH) begin
          mode_d = M_ESC;
        end else if (is_ctrl) begin
          cmd.t_en   = 1'b1;
          cmd.t_kind = K_ERROR;
          mode_d     = M_IDLE;
        end else begin
          cmd.t_en  = 1'b1;
          cmd.t_val = 1'b1;
        end
      end
      M_ESC: begin
        cmd.t_en  = 1'b1;
        cmd.t_val = 1'b1;
        mode_d    = M_QUOTE;
      end
      M_WORD: begin
        if (is_word) begin
          priority if (long_q) begin
            cmd.t_en  = 1'b1;
            cmd.t_val = 1'b1;
          end else if (cnt_q < HC_W'(KEYWORD_MAX_LEN)) begin
            held_d[cnt_q[HI_W-1:0]] = in_byte_i;
            cnt_d = cnt_q + HC_W'(1);
          end else begin
            // The word can no longer be a keyword: release what was held.
            cmd.held_n = cnt_q;
            cmd.t_en   = 1'b1;
            cmd.t_val  = 1'b1;
            cnt_d      = '0;
            long_d     = 1'b1;
          end
        end else begin
          cmd.a_en = 1'b1;
          if (!long_q && kw_hit) begin
            cmd.a_kind = kw_kind;
          end else begin
            cmd.a_kind = K_STRING;
            if (!long_q) begin
              cmd.held_n = cnt_q;
            end
          end
          cnt_d    = '0;
          long_d   = 1'b0;
          run_idle = 1'b1;
        end
      end
      default: begin
        run_idle = 1'b1;
      end
    endcase

    // The ending byte of a number or word is classified again from idle.
    if (run_idle) begin
      mode_d = M_IDLE;
      priority if (in_byte_i == CH_NL) begin
        cmd.t_en   = 1'b1;
        cmd.t_kind = K_NEWLINE;
      end else if (is_ctrl) begin
        cmd.t_en   = 1'b1;
        cmd.t_kind = K_ERROR;
      end else if (in_byte_i == CH_SPACE) begin
        mode_d = M_IDLE;
      end else if (is_digit) begin
        cmd.t_en  = 1'b1;
        cmd.t_val = 1'b1;
        mode_d    = M_NUM;
      end else if (in_byte_i == CH_QUOTE) begin
        mode_d = M_QUOTE;
      end else begin
        held_d[0] = in_byte_i;
        cnt_d     = HC_W'(1);
        long_d    = 1'b0;
        mode_d    = M_WORD;
      end
    end
  end

  assign cmd_o  = cmd;
  assign push_o = accept && ((cmd.held_n != '0) || cmd.a_en || cmd.t_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_IDLE;
      held_q <= '0;
      cnt_q  <= '0;
      long_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      held_q <= held_d;
      cnt_q  <= cnt_d;
      long_q <= long_d;
    end
  end

endmodule

// ===== hw/rtl/clt_fifo.sv =====
module clt_fifo import clt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t          slot_q [QUEUE_DEPTH];
  logic [QA_W:0] wr_q, rd_q;

  assign valid_o = (wr_q != rd_q);
  assign full_o  = (wr_q[QA_W] != rd_q[QA_W]) && (wr_q[QA_W-1:0] == rd_q[QA_W-1:0]);
  assign cmd_o   = slot_q[rd_q[QA_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q[QA_W-1:0]] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + (QA_W+1)'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + (QA_W+1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/clt_back.sv =====
module clt_back import clt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_value_byte_o,
  output logic [7:0] value_byte_o,
  output logic [3:0] token_kind_o,
  output logic       last_of_run_o
);

  logic [ST_W-1:0] step_q, step_d;
  logic [ST_W-1:0] total;
  logic            beat;
  logic            in_held, at_tok;

  assign total   = ST_W'(cmd_i.held_n) + ST_W'(cmd_i.a_en) + ST_W'(cmd_i.t_en);
  assign in_held = step_q < ST_W'(cmd_i.held_n);
  assign at_tok  = !in_held && cmd_i.a_en && (step_q == ST_W'(cmd_i.held_n));

  assign out_valid_o   = cmd_valid_i;
  assign last_of_run_o = (step_q == total - ST_W'(1));
  assign beat          = cmd_valid_i && !out_stall_i;
  assign pop_o         = beat && last_of_run_o;

  always_comb begin
    is_value_byte_o = 1'b0;
    value_byte_o    = 8'h00;
    token_kind_o    = K_ERROR;
    priority if (in_held) begin
      is_value_byte_o = 1'b1;
      value_byte_o    = cmd_i.held[step_q[HI_W-1:0]];
    end else if (at_tok) begin
      token_kind_o = cmd_i.a_kind;
    end else if (cmd_i.t_val) begin
      is_value_byte_o = 1'b1;
      value_byte_o    = cmd_i.data;
    end else begin
      token_kind_o = cmd_i.t_kind;
    end
  end

  always_comb begin
    step_d = step_q;
    if (beat) begin
      step_d = last_of_run_o ? '0 : step_q + ST_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ===== hw/rtl/clt_checker.sv =====
module clt_checker import clt_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       is_value_byte_o,
  input logic [7:0] value_byte_o,
  input logic [3:0] token_kind_o,
  input logic       last_of_run_o
);

  // A stalled result holds all of its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_value_byte_o)
      && $stable(value_byte_o) && $stable(token_kind_o) && $stable(last_of_run_o))
    else $error("stalled result changed");

  // The results of one byte leave without a gap.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside the results of one byte");

  // Input back-pressure only appears while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with nothing to deliver");

  // A newline token is always the final result of its byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_value_byte_o && token_kind_o == K_NEWLINE |-> last_of_run_o)
    else $error("newline token not last of run");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .is_value_byte_o (is_value_byte_o),
  .value_byte_o    (value_byte_o),
  .token_kind_o    (token_kind_o),
  .last_of_run_o   (last_of_run_o)
);
